>>> design/direct_mapped_writeback_cache_ctrl_top_assert.svh
// assertion macros for the cache controller
// no dependencies
`ifndef DIRECT_MAPPED_WRITEBACK_CACHE_CTRL_TOP_ASSERT_SVH
`define DIRECT_MAPPED_WRITEBACK_CACHE_CTRL_TOP_ASSERT_SVH
`define DMC_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define DMC_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> design/dmc_pkg.sv
// package for the cache controller: payload types, defaults, codes
// no dependencies
`timescale 1ns / 1ps
package dmc_pkg;
    localparam int LINES_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int INFLIGHT_DEPTH_DEF = 8;
    localparam int DROPPED_DEPTH_DEF = 8;
    localparam logic [1:0] ACT_READ = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_RESP = 2'd2;
    localparam logic [1:0] ACT_DRAIN = 2'd3;
    localparam logic [0:0] REG_BASE = 1'd0;
    localparam logic [0:0] REG_EBYTES = 1'd1;
    localparam logic [4:0] DROP_MAX = 5'd31;
    typedef struct packed {
        logic [1:0] action;
        logic [23:0] entry_offset;
        logic [63:0] write_word;
        logic [39:0] response_address;
        logic [63:0] fill_word;
        logic memory_ready;
    } t_in;
    typedef struct packed {
        logic hit;
        logic [63:0] read_word;
        logic response_claimed;
        logic issue_valid;
        logic [39:0] issue_address;
        logic issue_is_write;
        logic overflow;
    } t_out;
endpackage

>>> design/dmc_ram.sv
// generic single-port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module dmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> design/direct_mapped_writeback_cache_ctrl_top.sv
// cache controller top level; depends on dmc_pkg, dmc_ram and the assertion macro header
// result registered in the output register after the S_RD, S_EXEC and S_OUT states; a read drain also passes S_DIV
// input stalls until the previous item has left S_OUT; a read drain adds a 40-step serial offset divide
// a result waiting for the receiver does not block the next input transfer
// reset: a clearing pass over all LINES entries invalidates every tag, queue and tables emptied
// line words are undefined until written
`timescale 1ns / 1ps
`include "direct_mapped_writeback_cache_ctrl_top_assert.svh"
module direct_mapped_writeback_cache_ctrl_top #(
    parameter int LINES = dmc_pkg::LINES_DEF,
    parameter int QUEUE_DEPTH = dmc_pkg::QUEUE_DEPTH_DEF,
    parameter int INFLIGHT_DEPTH = dmc_pkg::INFLIGHT_DEPTH_DEF,
    parameter int DROPPED_DEPTH = dmc_pkg::DROPPED_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  dmc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output dmc_pkg::t_out o_data,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);
    localparam int IW = $clog2(LINES);
    localparam int TW = 24 - IW;
    localparam int QW = $clog2(QUEUE_DEPTH + 1);
    localparam int FW = (INFLIGHT_DEPTH > 1) ? $clog2(INFLIGHT_DEPTH) : 1;
    localparam int DW = (DROPPED_DEPTH > 1) ? $clog2(DROPPED_DEPTH) : 1;
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV = 3'd3;
    localparam logic [2:0] S_OUT = 3'd4;
    localparam logic [2:0] S_CLR = 3'd5;

    logic [39:0] r_base;
    logic [6:0] r_ebytes;
    logic [2:0] r_state;
    dmc_pkg::t_in r_in;
    dmc_pkg::t_out r_res;
    dmc_pkg::t_out r_out;
    logic r_ovalid;
    logic [39:0] r_addr;
    logic [IW-1:0] r_clr;
    logic [39:0] r_qaddr [QUEUE_DEPTH];
    logic r_qwr [QUEUE_DEPTH];
    logic [QW-1:0] r_qcnt;
    logic r_fused [INFLIGHT_DEPTH];
    logic [39:0] r_faddr [INFLIGHT_DEPTH];
    logic [23:0] r_foff [INFLIGHT_DEPTH];
    logic [4:0] r_dcnt [DROPPED_DEPTH];
    logic [39:0] r_daddr [DROPPED_DEPTH];
    logic [39:0] r_rem;
    logic [39:0] r_quo;
    logic [5:0] r_dstep;
    logic [39:0] r_haddr;

    // tag memory: valid, tag and dirty, data memory: word
    logic tag_we, word_we;
    logic [IW-1:0] mem_idx;
    logic [TW+1:0] tag_wdata, tag_rdata;
    logic [63:0] word_wdata, word_rdata;

    dmc_ram #(.WIDTH(TW + 2), .DEPTH(LINES)) u_tag (
        .i_clk(i_clk), .i_we(tag_we), .i_addr(mem_idx),
        .i_wdata(tag_wdata), .o_rdata(tag_rdata));
    dmc_ram #(.WIDTH(64), .DEPTH(LINES)) u_word (
        .i_clk(i_clk), .i_we(word_we), .i_addr(mem_idx),
        .i_wdata(word_wdata), .o_rdata(word_rdata));

    logic take;
    logic load_out;
    assign take = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign load_out = (r_state == S_OUT) && (!r_ovalid || !i_stall);
    assign o_valid = r_ovalid;
    assign o_data = r_out;
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3])
            dmc_pkg::REG_BASE:   prdata = {24'd0, r_base};
            dmc_pkg::REG_EBYTES: prdata = {57'd0, r_ebytes};
            default:             prdata = 64'd0;
        endcase
    end

    // line index: on responses it comes from the inflight entry
    logic [23:0] cur_off;
    logic fhit;
    logic [FW-1:0] fidx;
    logic dhit;
    logic [DW-1:0] didx;
    logic [39:0] srch;
    assign srch = (r_in.action == dmc_pkg::ACT_RESP) ? r_in.response_address :
                  ((r_in.action == dmc_pkg::ACT_DRAIN) ? r_haddr : r_addr);
    always_comb begin
        fhit = 1'b0;
        fidx = '0;
        for (int i = INFLIGHT_DEPTH - 1; i >= 0; i--) begin
            if (r_fused[i] && r_faddr[i] == srch) begin
                fhit = 1'b1;
                fidx = FW'(i);
            end
        end
        dhit = 1'b0;
        didx = '0;
        for (int i = DROPPED_DEPTH - 1; i >= 0; i--) begin
            if (r_dcnt[i] != 5'd0 && r_daddr[i] == srch) begin
                dhit = 1'b1;
                didx = DW'(i);
            end
        end
    end
    assign cur_off = (r_in.action == dmc_pkg::ACT_RESP) ? r_foff[fidx] : r_in.entry_offset;
    assign mem_idx = (r_state == S_IDLE) ? i_data.entry_offset[IW-1:0] :
                     ((r_state == S_CLR) ? r_clr : cur_off[IW-1:0]);

    // free slots and queue match
    logic ffree_ok, dfree_ok, qm_ok, qrd;
    logic [FW-1:0] ffree;
    logic [DW-1:0] dfree;
    logic [QW-1:0] qm;
    always_comb begin
        ffree_ok = 1'b0;
        ffree = '0;
        for (int i = INFLIGHT_DEPTH - 1; i >= 0; i--) begin
            if (!r_fused[i]) begin
                ffree_ok = 1'b1;
                ffree = FW'(i);
            end
        end
        dfree_ok = 1'b0;
        dfree = '0;
        for (int i = DROPPED_DEPTH - 1; i >= 0; i--) begin
            if (r_dcnt[i] == 5'd0) begin
                dfree_ok = 1'b1;
                dfree = DW'(i);
            end
        end
        qm_ok = 1'b0;
        qm = '0;
        qrd = 1'b0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (QW'(i) < r_qcnt && r_qaddr[i] == r_addr) begin
                qm_ok = 1'b1;
                qm = QW'(i);
                if (!r_qwr[i]) qrd = 1'b1;
            end
        end
    end

    logic lv, lh, ldirty;
    logic [TW-1:0] ltag;
    logic [39:0] vaddr;
    logic [23:0] voff;
    assign lv = tag_rdata[TW+1];
    assign ltag = tag_rdata[TW:1];
    assign ldirty = tag_rdata[0];
    assign lh = lv && ltag == r_in.entry_offset[23:IW];
    assign voff = {ltag, r_in.entry_offset[IW-1:0]};
    assign vaddr = r_base + 40'(voff * r_ebytes);

    always_comb begin
        tag_we = 1'b0;
        word_we = 1'b0;
        tag_wdata = {1'b1, r_in.entry_offset[23:IW], 1'b1};
        word_wdata = r_in.write_word;
        if (r_state == S_CLR) begin
            tag_we = 1'b1;
            tag_wdata = '0;
        end else if (r_state == S_EXEC) begin
            if (r_in.action == dmc_pkg::ACT_WRITE) begin
                tag_we = 1'b1;
                word_we = 1'b1;
            end else if (r_in.action == dmc_pkg::ACT_RESP && !dhit && fhit) begin
                tag_we = 1'b1;
                word_we = 1'b1;
                tag_wdata = {1'b1, r_foff[fidx][23:IW], 1'b0};
                word_wdata = r_in.fill_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 40'd0;
            r_ebytes <= 7'd12;
            r_state <= S_CLR;
            r_clr <= '0;
            r_ovalid <= 1'b0;
            r_qcnt <= '0;
            for (int i = 0; i < INFLIGHT_DEPTH; i++) r_fused[i] <= 1'b0;
            for (int i = 0; i < DROPPED_DEPTH; i++) r_dcnt[i] <= 5'd0;
        end else begin
            if (psel && penable && pwrite) begin
                unique case (paddr[3])
                    dmc_pkg::REG_BASE:   r_base <= pwdata[39:0];
                    dmc_pkg::REG_EBYTES: r_ebytes <= pwdata[6:0];
                    default: ;
                endcase
            end
            if (load_out) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IW'(LINES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (take) begin
                        r_in <= i_data;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_addr <= r_base + 40'(r_in.entry_offset * r_ebytes);
                    r_haddr <= r_qaddr[0];
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    dmc_pkg::t_out n_out;
                    n_out = '0;
                    r_state <= S_OUT;
                    case (r_in.action)
                        dmc_pkg::ACT_READ: begin
                            n_out.hit = lh;
                            n_out.read_word = word_rdata;
                            if (!lh && !fhit && !qrd) begin
                                if (r_qcnt < QW'(QUEUE_DEPTH)) begin
                                    r_qaddr[r_qcnt[$clog2(QUEUE_DEPTH)-1:0]] <= r_addr;
                                    r_qwr[r_qcnt[$clog2(QUEUE_DEPTH)-1:0]] <= 1'b0;
                                    r_qcnt <= r_qcnt + 1'b1;
                                end else begin
                                    n_out.overflow = 1'b1;
                                end
                            end
                        end
                        dmc_pkg::ACT_WRITE: begin
                            logic pushed;
                            logic [QW-1:0] cnt;
                            logic mo;
                            logic [QW-1:0] mp;
                            pushed = 1'b0;
                            n_out.hit = lh;
                            n_out.read_word = r_in.write_word;
                            if (!lh && lv && ldirty) begin
                                if (r_qcnt < QW'(QUEUE_DEPTH)) pushed = 1'b1;
                                else n_out.overflow = 1'b1;
                            end
                            mo = qm_ok;
                            mp = qm;
                            if (!qm_ok && pushed && vaddr == r_addr) begin
                                mo = 1'b1;
                                mp = r_qcnt;
                            end
                            // build new queue: append victim, then remove match
                            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                                logic [39:0] a;
                                logic w;
                                a = r_qaddr[i];
                                w = r_qwr[i];
                                if (pushed && QW'(i) == r_qcnt) begin
                                    a = vaddr;
                                    w = 1'b1;
                                end
                                if (mo && QW'(i) >= mp) begin
                                    if (i + 1 < QUEUE_DEPTH) begin
                                        if (pushed && QW'(i + 1) == r_qcnt) begin
                                            a = vaddr;
                                            w = 1'b1;
                                        end else begin
                                            a = r_qaddr[i + 1];
                                            w = r_qwr[i + 1];
                                        end
                                    end
                                end
                                r_qaddr[i] <= a;
                                r_qwr[i] <= w;
                            end
                            cnt = r_qcnt + QW'(pushed) - QW'(mo);
                            r_qcnt <= cnt;
                            if (fhit) begin
                                r_fused[fidx] <= 1'b0;
                                if (dhit) begin
                                    if (r_dcnt[didx] < dmc_pkg::DROP_MAX)
                                        r_dcnt[didx] <= r_dcnt[didx] + 5'd1;
                                end else if (dfree_ok) begin
                                    r_daddr[dfree] <= r_addr;
                                    r_dcnt[dfree] <= 5'd1;
                                end else begin
                                    n_out.overflow = 1'b1;
                                end
                            end
                        end
                        dmc_pkg::ACT_RESP: begin
                            if (dhit) begin
                                r_dcnt[didx] <= r_dcnt[didx] - 5'd1;
                                n_out.response_claimed = 1'b1;
                            end else if (fhit) begin
                                r_fused[fidx] <= 1'b0;
                                n_out.response_claimed = 1'b1;
                            end
                        end
                        default: begin
                            if (r_qcnt != '0 && r_in.memory_ready) begin
                                n_out.issue_valid = 1'b1;
                                n_out.issue_address = r_haddr;
                                n_out.issue_is_write = r_qwr[0];
                                for (int i = 0; i + 1 < QUEUE_DEPTH; i++) begin
                                    r_qaddr[i] <= r_qaddr[i + 1];
                                    r_qwr[i] <= r_qwr[i + 1];
                                end
                                r_qcnt <= r_qcnt - 1'b1;
                                if (!r_qwr[0]) begin
                                    r_rem <= '0;
                                    r_quo <= r_haddr - r_base;
                                    r_dstep <= 6'd0;
                                    r_state <= S_DIV;
                                end
                            end
                        end
                    endcase
                    r_res <= n_out;
                end
                S_DIV: begin
                    // restoring divide, one quotient bit a cycle
                    logic [40:0] t;
                    logic [6:0] dv;
                    dv = (r_ebytes == 7'd0) ? 7'd1 : r_ebytes;
                    t = {r_rem, r_quo[39]};
                    if (t >= {34'd0, dv}) begin
                        r_rem <= 40'(t - {34'd0, dv});
                        r_quo <= {r_quo[38:0], 1'b1};
                    end else begin
                        r_rem <= t[39:0];
                        r_quo <= {r_quo[38:0], 1'b0};
                    end
                    r_dstep <= r_dstep + 6'd1;
                    if (r_dstep == 6'd39) begin
                        r_state <= S_OUT;
                        if (fhit) begin
                            r_foff[fidx] <= {r_quo[22:0], t >= {34'd0, dv}};
                        end else if (ffree_ok) begin
                            r_fused[ffree] <= 1'b1;
                            r_faddr[ffree] <= r_haddr;
                            r_foff[ffree] <= {r_quo[22:0], t >= {34'd0, dv}};
                        end else begin
                            r_res.overflow <= 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_out <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `DMC_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `DMC_ASSERT_NXT(a_out_follows, i_clk, i_rst_n, r_state == S_OUT, o_valid)
    `DMC_ASSERT_IMP(a_qcnt_max, i_clk, i_rst_n, 1'b1, r_qcnt <= QW'(QUEUE_DEPTH))
endmodule

>>> dv/testbench.sv
// testbench for the direct-mapped write-back cache controller: directed, overflow and random
// traffic with a built-in predictor and an in-order result check
// depends on dmc_pkg and direct_mapped_writeback_cache_ctrl_top
`timescale 1ns / 1ps
module testbench;
    localparam logic [39:0] ADDR_MAX = 40'hFF_FFFF_FFFF;
    localparam int WATCHDOG_LIMIT = 4000;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    dmc_pkg::t_in i_data;
    logic o_valid;
    logic i_stall;
    dmc_pkg::t_out o_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [3:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic pready;

    direct_mapped_writeback_cache_ctrl_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct packed {
        logic [39:0] addr;
        logic wr;
    } t_req;

    // predictor state
    logic [39:0] base_addr;
    logic [6:0] entry_bytes;
    logic [13:0] line_tag [dmc_pkg::LINES_DEF];
    logic line_valid [dmc_pkg::LINES_DEF];
    logic line_dirty [dmc_pkg::LINES_DEF];
    logic [63:0] line_word [dmc_pkg::LINES_DEF];
    bit line_written [dmc_pkg::LINES_DEF];
    t_req pending_reqs [$];
    logic fl_used [dmc_pkg::INFLIGHT_DEPTH_DEF];
    logic [39:0] fl_addr [dmc_pkg::INFLIGHT_DEPTH_DEF];
    logic [23:0] fl_off [dmc_pkg::INFLIGHT_DEPTH_DEF];
    logic [4:0] dr_count [dmc_pkg::DROPPED_DEPTH_DEF];
    logic [39:0] dr_addr [dmc_pkg::DROPPED_DEPTH_DEF];

    dmc_pkg::t_out expected_results [$];
    int errors;
    int idle_pct;
    int stall_pct;
    int idle_cycles;

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [39:0] entry_addr(input logic [23:0] off);
        logic [63:0] sum;
        sum = 64'(base_addr) + 64'(off) * 64'(entry_bytes);
        return sum[39:0];
    endfunction

    function automatic int find_inflight(input logic [39:0] a);
        for (int i = 0; i < dmc_pkg::INFLIGHT_DEPTH_DEF; i++)
            if (fl_used[i] && fl_addr[i] == a) return i;
        return -1;
    endfunction

    function automatic int find_dropped(input logic [39:0] a);
        for (int i = 0; i < dmc_pkg::DROPPED_DEPTH_DEF; i++)
            if (dr_count[i] != 0 && dr_addr[i] == a) return i;
        return -1;
    endfunction

    function automatic dmc_pkg::t_out cache_predict(input dmc_pkg::t_in it);
        dmc_pkg::t_out r;
        logic [9:0] idx;
        logic [13:0] tg;
        logic [39:0] a;
        logic h;
        logic was_dirty;
        logic [13:0] old_tag;
        logic queued;
        int f;
        int d;
        t_req hd;
        logic [63:0] dv;
        logic [39:0] diff;
        r = '0;
        idx = it.entry_offset[9:0];
        tg = it.entry_offset[23:10];
        a = entry_addr(it.entry_offset);
        case (it.action)
            dmc_pkg::ACT_READ, dmc_pkg::ACT_WRITE: begin
                h = line_valid[idx] && line_tag[idx] == tg;
                r.hit = h;
                if (it.action == dmc_pkg::ACT_WRITE) begin
                    was_dirty = line_valid[idx] && line_dirty[idx];
                    old_tag = line_tag[idx];
                    if (!h) begin
                        line_tag[idx] = tg;
                        line_valid[idx] = 1;
                    end
                    if (!h && was_dirty) begin
                        if (pending_reqs.size() < dmc_pkg::QUEUE_DEPTH_DEF)
                            pending_reqs.insert(pending_reqs.size(),
                                                t_req'{entry_addr({old_tag, idx}), 1'b1});
                        else
                            r.overflow = 1;
                    end
                    line_word[idx] = it.write_word;
                    line_written[idx] = 1;
                    line_dirty[idx] = 1;
                    foreach (pending_reqs[i])
                        if (pending_reqs[i].addr == a) begin
                            pending_reqs.delete(i);
                            break;
                        end
                    f = find_inflight(a);
                    if (f >= 0) begin
                        fl_used[f] = 0;
                        d = find_dropped(a);
                        if (d >= 0) begin
                            if (dr_count[d] < dmc_pkg::DROP_MAX) dr_count[d]++;
                        end else begin
                            for (d = 0; d < dmc_pkg::DROPPED_DEPTH_DEF; d++)
                                if (dr_count[d] == 0) break;
                            if (d < dmc_pkg::DROPPED_DEPTH_DEF) begin
                                dr_addr[d] = a;
                                dr_count[d] = 1;
                            end else begin
                                r.overflow = 1;
                            end
                        end
                    end
                end else if (!h) begin
                    queued = 0;
                    foreach (pending_reqs[i])
                        if (pending_reqs[i].addr == a && !pending_reqs[i].wr) queued = 1;
                    if (find_inflight(a) < 0 && !queued) begin
                        if (pending_reqs.size() < dmc_pkg::QUEUE_DEPTH_DEF)
                            pending_reqs.insert(pending_reqs.size(), t_req'{a, 1'b0});
                        else
                            r.overflow = 1;
                    end
                end
                r.read_word = line_word[idx];
            end
            dmc_pkg::ACT_RESP: begin
                d = find_dropped(it.response_address);
                if (d >= 0) begin
                    dr_count[d]--;
                    r.response_claimed = 1;
                end else begin
                    f = find_inflight(it.response_address);
                    if (f >= 0) begin
                        idx = fl_off[f][9:0];
                        line_tag[idx] = fl_off[f][23:10];
                        line_valid[idx] = 1;
                        line_dirty[idx] = 0;
                        line_word[idx] = it.fill_word;
                        line_written[idx] = 1;
                        fl_used[f] = 0;
                        r.response_claimed = 1;
                    end
                end
            end
            default: begin
                if (pending_reqs.size() > 0 && it.memory_ready) begin
                    hd = pending_reqs[0];
                    pending_reqs.delete(0);
                    r.issue_valid = 1;
                    r.issue_address = hd.addr;
                    r.issue_is_write = hd.wr;
                    if (!hd.wr) begin
                        dv = (entry_bytes == 0) ? 64'd1 : 64'(entry_bytes);
                        diff = hd.addr - base_addr;
                        f = find_inflight(hd.addr);
                        if (f < 0)
                            for (f = 0; f < dmc_pkg::INFLIGHT_DEPTH_DEF; f++)
                                if (!fl_used[f]) break;
                        if (f < dmc_pkg::INFLIGHT_DEPTH_DEF) begin
                            fl_used[f] = 1;
                            fl_addr[f] = hd.addr;
                            fl_off[f] = 24'(64'(diff) / dv);
                        end else begin
                            r.overflow = 1;
                        end
                    end
                end
            end
        endcase
        return r;
    endfunction

    // receiver stall
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // result check
    always @(posedge i_clk) begin
        dmc_pkg::t_out exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result %p", o_data);
            end else begin
                exp_r = expected_results[0];
                expected_results.delete(0);
                if (o_data.hit !== exp_r.hit || o_data.read_word !== exp_r.read_word
                    || o_data.response_claimed !== exp_r.response_claimed
                    || o_data.issue_valid !== exp_r.issue_valid
                    || o_data.issue_address !== exp_r.issue_address
                    || o_data.issue_is_write !== exp_r.issue_is_write
                    || o_data.overflow !== exp_r.overflow) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %p actual %p", exp_r, o_data);
                end
            end
        end
    end

    // watchdog on transfers
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_item(input dmc_pkg::t_in it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid = 0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_data = it;
        i_valid = 1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_results.insert(expected_results.size(), cache_predict(it));
    endtask

    task automatic send_op(input logic [1:0] act, input logic [23:0] off,
                           input logic [63:0] w, input logic [39:0] ra, input logic rdy);
        dmc_pkg::t_in it;
        it.action = act;
        it.entry_offset = off;
        it.write_word = w;
        it.response_address = ra;
        it.fill_word = {$urandom, $urandom};
        it.memory_ready = rdy;
        send_item(it);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_valid = 0;
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [3:0] a, input logic [63:0] v);
        logic [63:0] rb_exp;
        @(negedge i_clk);
        psel = 1;
        pwrite = 1;
        penable = 0;
        paddr = a;
        pwdata = v;
        @(negedge i_clk);
        penable = 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (a == 4'(8 * dmc_pkg::REG_BASE)) begin
            base_addr = v[39:0];
            rb_exp = {24'd0, base_addr};
        end else begin
            entry_bytes = v[6:0];
            rb_exp = {57'd0, entry_bytes};
        end
        @(negedge i_clk);
        if (prdata !== rb_exp) begin
            errors++;
            if (errors <= 10)
                $display("register readback: expected %h actual %h", rb_exp, prdata);
        end
        psel = 0;
        penable = 0;
    endtask

    task automatic configure(input logic [63:0] b, input logic [63:0] eb);
        wait_idle();
        apb_write(4'(8 * dmc_pkg::REG_BASE), b);
        apb_write(4'(8 * dmc_pkg::REG_EBYTES), eb);
    endtask

    function automatic logic [23:0] pick_offset();
        logic [9:0] idx;
        logic [13:0] tg;
        case ($urandom_range(3))
            0: idx = 10'($urandom_range(7));
            1: idx = 10'd1023 - 10'($urandom_range(3));
            2: idx = 10'(100 + $urandom_range(19));
            default: idx = 10'($urandom);
        endcase
        case ($urandom_range(4))
            0: tg = 14'd0;
            1: tg = 14'd1;
            2: tg = 14'h3FFF;
            3: tg = 14'($urandom_range(3));
            default: tg = 14'($urandom);
        endcase
        return {tg, idx};
    endfunction

    function automatic logic [39:0] pick_resp_addr();
        logic [39:0] pool [$];
        for (int i = 0; i < dmc_pkg::INFLIGHT_DEPTH_DEF; i++)
            if (fl_used[i]) pool.insert(pool.size(), fl_addr[i]);
        for (int i = 0; i < dmc_pkg::DROPPED_DEPTH_DEF; i++)
            if (dr_count[i] != 0) pool.insert(pool.size(), dr_addr[i]);
        if (pool.size() == 0 || $urandom_range(9) == 0) return 40'({$urandom, $urandom});
        return pool[$urandom_range(pool.size() - 1)];
    endfunction

    task automatic test_directed();
        send_op(dmc_pkg::ACT_WRITE, 24'd0, 64'h0123_4567_89AB_CDEF, '0, 1'b0);
        send_op(dmc_pkg::ACT_READ, 24'd0, '0, '0, 1'b0);
        send_op(dmc_pkg::ACT_WRITE, 24'd1024, '0, ADDR_MAX, 1'b1);
        send_op(dmc_pkg::ACT_DRAIN, '0, '1, '0, 1'b0);
        send_op(dmc_pkg::ACT_DRAIN, '0, '0, '0, 1'b1);
        send_op(dmc_pkg::ACT_DRAIN, '0, '0, '0, 1'b1);
        send_op(dmc_pkg::ACT_WRITE, 24'hFFFFFF, '1, '0, 1'b0);
        send_op(dmc_pkg::ACT_READ, 24'd1023, '0, '0, 1'b0);
        send_op(dmc_pkg::ACT_READ, 24'd1023, '0, '0, 1'b0);
        send_op(dmc_pkg::ACT_DRAIN, '0, '0, '0, 1'b1);
        send_op(dmc_pkg::ACT_READ, 24'd1023, '0, '0, 1'b0);
        send_op(dmc_pkg::ACT_RESP, '0, '0, 40'(1023 * 12), 1'b0);
        send_op(dmc_pkg::ACT_READ, 24'd1023, '0, '0, 1'b0);
        send_op(dmc_pkg::ACT_READ, 24'd2047, '0, '0, 1'b0);
        send_op(dmc_pkg::ACT_WRITE, 24'd2047, 64'h5555_AAAA_5555_AAAA, '0, 1'b0);
        send_op(dmc_pkg::ACT_READ, 24'd0, '0, '0, 1'b0);
        send_op(dmc_pkg::ACT_DRAIN, '0, '0, '0, 1'b1);
        send_op(dmc_pkg::ACT_WRITE, 24'd0, 64'hFEED, '0, 1'b0);
        send_op(dmc_pkg::ACT_RESP, '0, '0, 40'd0, 1'b0);
        send_op(dmc_pkg::ACT_RESP, '0, '0, ADDR_MAX, 1'b0);
        send_op(dmc_pkg::ACT_DRAIN, '0, '0, '0, 1'b1);
        send_op(dmc_pkg::ACT_DRAIN, '0, '0, '0, 1'b1);
    endtask

    // fill the queue and both tables past their depth
    task automatic test_overflow();
        for (int i = 100; i < 120; i++)
            send_op(dmc_pkg::ACT_WRITE, 24'(i), {$urandom, $urandom}, '0, 1'b0);
        for (int i = 100; i < 120; i++)
            send_op(dmc_pkg::ACT_READ, 24'(1024 + i), '0, '0, 1'b0);
        for (int i = 0; i < 12; i++) send_op(dmc_pkg::ACT_DRAIN, '0, '0, '0, 1'b1);
        for (int i = 100; i < 110; i++)
            send_op(dmc_pkg::ACT_WRITE, 24'(1024 + i), '1, '0, 1'b0);
        for (int i = 0; i < 4; i++) send_op(dmc_pkg::ACT_RESP, '0, '0, pick_resp_addr(), 1'b0);
        while (pending_reqs.size() != 0) send_op(dmc_pkg::ACT_DRAIN, '0, '0, '0, 1'b1);
    endtask

    task automatic test_random(input int n);
        logic [1:0] act;
        logic [23:0] off;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(9))
                0, 1, 2: act = dmc_pkg::ACT_READ;
                3, 4: act = dmc_pkg::ACT_WRITE;
                5, 6, 7: act = dmc_pkg::ACT_DRAIN;
                default: act = dmc_pkg::ACT_RESP;
            endcase
            off = pick_offset();
            if (act == dmc_pkg::ACT_READ && !line_written[off[9:0]]) act = dmc_pkg::ACT_WRITE;
            send_op(act, off, {$urandom, $urandom}, pick_resp_addr(),
                    $urandom_range(99) < 85);
        end
    endtask

    initial begin
        errors = 0;
        idle_cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        i_valid = 0;
        i_data = '0;
        i_stall = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        base_addr = '0;
        entry_bytes = 7'd12;
        for (int i = 0; i < dmc_pkg::LINES_DEF; i++) begin
            line_tag[i] = '0;
            line_valid[i] = 0;
            line_dirty[i] = 0;
            line_word[i] = '0;
            line_written[i] = 0;
        end
        for (int i = 0; i < dmc_pkg::INFLIGHT_DEPTH_DEF; i++) fl_used[i] = 0;
        for (int i = 0; i < dmc_pkg::DROPPED_DEPTH_DEF; i++) dr_count[i] = '0;
        i_rst_n = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        test_directed();
        test_overflow();
        test_random(150);
        configure(64'h0, 64'd1);
        idle_pct = 58;
        test_random(150);
        configure({24'hFFFFFF, ADDR_MAX}, 64'd64);
        idle_pct = 0;
        stall_pct = 58;
        test_random(150);
        configure({$urandom, $urandom}, 64'd0);
        idle_pct = 6;
        stall_pct = 6;
        test_random(100);
        configure({$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FF7F);
        test_random(60);

        wait_idle();
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
